FILE: sv/ffa_pkg.sv
package ffa_pkg;

    localparam int HEAP_BYTES      = 65536;
    localparam int PAGE_BYTES      = 4096;
    localparam int HEADER_BYTES    = 8;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int GRAIN_BYTES     = 4;

    localparam int INIT_BYTES = (PAGE_BYTES <= HEAP_BYTES) ? PAGE_BYTES : HEAP_BYTES;
    localparam int SLOTS      = HEAP_BYTES / GRAIN_BYTES;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int OFF_W      = $clog2(HEAP_BYTES) + 1;
    localparam int GRAIN_SH   = $clog2(GRAIN_BYTES);
    localparam int PAGE_SH    = $clog2(PAGE_BYTES);
    localparam int SPLIT_MIN  = HEADER_BYTES + MIN_BLOCK_BYTES;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_INVAL  = 2'd1;
    localparam logic [1:0] ST_DOUBLE = 2'd2;
    localparam logic [1:0] ST_LIMIT  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             used;
        logic [OFF_W-1:0] size;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

endpackage

FILE: sv/ffa_req_if.sv
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] req_size;
    logic [31:0] block_addr;

    modport source (output valid, output operation, output req_size, output block_addr,
                    input ready);
    modport sink   (input valid, input operation, input req_size, input block_addr,
                    output ready);
endinterface

FILE: sv/ffa_rsp_if.sv
interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_addr;
    logic [1:0]  status;

    modport source (output valid, output payload_addr, output status, input ready);
    modport sink   (input valid, input payload_addr, input status, output ready);
endinterface

FILE: sv/ffa_cfg_if.sv
interface ffa_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/first_fit_heap_allocator_top.sv
// Channel | dir | word                                  | accepted when
// req     | in  | operation, req_size, block_addr       | req.valid && req.ready
// rsp     | out | payload_addr, status                  | rsp.valid && rsp.ready
// cfg     | in  | index (0 base, 1 limit pages), wdata  | cfg.valid && cfg.ready
//
// One request at a time. Allocate: one RAM read (S_ARD) and one check
// (S_ACHK) per block header walked, then split (S_TAKE), write back (S_WRI)
// and load the answer (S_RESP), after S_GROW when the heap has to grow. Free:
// a check, a read and a check per merged neighbor, one more when a used
// neighbor ends the merge, then write back; a rejected request goes to S_RESP.
// After reset a clearing pass sweeps the whole header RAM; req.ready
// stays low meanwhile, cfg is always taken. A finished word waits in the rsp
// register; the next request is taken while it is stalled there.
module first_fit_heap_allocator_top (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp,
    ffa_cfg_if.sink   cfg
);

    localparam int OW = ffa_pkg::OFF_W;
    localparam int IW = ffa_pkg::IDX_W;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ARD   = 4'd2;
    localparam logic [3:0] S_ACHK  = 4'd3;
    localparam logic [3:0] S_GROW  = 4'd4;
    localparam logic [3:0] S_TAKE  = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_MRD   = 4'd7;
    localparam logic [3:0] S_MCHK  = 4'd8;
    localparam logic [3:0] S_WRI   = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [31:0]   base_reg;
    logic [4:0]    limit_reg;
    logic [OW-1:0] top_reg, top_next;
    logic [OW-1:0] off_reg, off_next;
    logic [OW-1:0] need_reg, need_next;
    logic [OW-1:0] size_reg, size_next;
    logic          used_reg, used_next;   // used mark written back in S_WRI
    logic          alloc_reg, alloc_next;
    logic [31:0]   pend_addr_reg, pend_addr_next;
    logic [1:0]    pend_st_reg, pend_st_next;
    logic          out_valid_reg;
    logic [31:0]   out_addr_reg;
    logic [1:0]    out_st_reg;

    logic            we;
    logic [IW-1:0]   waddr, raddr;
    ffa_pkg::hdr_t   wdata, rd;
    logic [ffa_pkg::HDR_W-1:0] rdata;

    // scratch
    logic [OW-1:0] need_sum, rem;
    logic [OW:0]   next_off;
    logic [31:0]   foff;
    logic [OW:0]   pg_sum;
    logic [OW:0]   grow;
    logic [OW:0]   lim;
    logic [OW+1:0] top_grow;
    logic          rsp_free;

    ffa_ram #(.WIDTH(ffa_pkg::HDR_W), .DEPTH(ffa_pkg::SLOTS)) u_hdr (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd       = rdata;
    assign rsp_free = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.payload_addr = out_addr_reg;
    assign rsp.status       = out_st_reg;

    always_comb
    begin
        need_sum = {1'b0, req.req_size} + OW'(ffa_pkg::HEADER_BYTES + ffa_pkg::GRAIN_BYTES - 1);
        foff     = req.block_addr - base_reg - 32'(ffa_pkg::HEADER_BYTES);
        next_off = {1'b0, off_reg} + {1'b0, size_reg};
        rem      = size_reg - need_reg;
        pg_sum   = {1'b0, need_reg} + (OW+1)'(ffa_pkg::PAGE_BYTES - 1);
        grow     = (pg_sum >> ffa_pkg::PAGE_SH) << ffa_pkg::PAGE_SH;
        lim      = (OW+1)'({limit_reg, {ffa_pkg::PAGE_SH{1'b0}}});
        if (lim > (OW+1)'(ffa_pkg::HEAP_BYTES))
        begin
            lim = (OW+1)'(ffa_pkg::HEAP_BYTES);
        end
        top_grow = {2'b0, top_reg} + {1'b0, grow};
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        top_next       = top_reg;
        off_next       = off_reg;
        need_next      = need_reg;
        size_next      = size_reg;
        used_next      = used_reg;
        alloc_next     = alloc_reg;
        pend_addr_next = pend_addr_reg;
        pend_st_next   = pend_st_reg;
        we             = 1'b0;
        waddr          = off_reg[ffa_pkg::GRAIN_SH +: IW];
        wdata          = '0;
        raddr          = off_reg[ffa_pkg::GRAIN_SH +: IW];

        unique case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    wdata.valid = 1'b1;
                    wdata.size  = OW'(ffa_pkg::INIT_BYTES);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(ffa_pkg::SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pend_addr_next = '0;
                    alloc_next     = (req.operation == ffa_pkg::OP_ALLOC);
                    if (req.operation == ffa_pkg::OP_ALLOC)
                    begin
                        need_next = need_sum & ~OW'(ffa_pkg::GRAIN_BYTES - 1);
                        off_next  = '0;
                        if (req.req_size == '0)
                        begin
                            pend_st_next = ffa_pkg::ST_INVAL;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            state_next = S_ARD;
                        end
                    end
                    else
                    begin
                        off_next = foff[OW-1:0];
                        raddr    = foff[ffa_pkg::GRAIN_SH +: IW];
                        if (foff[ffa_pkg::GRAIN_SH-1:0] != '0 || foff >= 32'(top_reg))
                        begin
                            pend_st_next = ffa_pkg::ST_INVAL;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            state_next = S_FCHK;
                        end
                    end
                end
            end
            S_ARD:
            begin
                state_next = (off_reg < top_reg) ? S_ACHK : S_GROW;
            end
            S_ACHK:
            begin
                if (!rd.valid || rd.size == '0)
                begin
                    state_next = S_GROW;
                end
                else if (!rd.used && need_reg <= rd.size)
                begin
                    size_next  = rd.size;
                    state_next = S_TAKE;
                end
                else
                begin
                    off_next   = off_reg + rd.size;
                    state_next = S_ARD;
                end
            end
            S_GROW:
            begin
                if (top_grow > {1'b0, lim})
                begin
                    pend_st_next = ffa_pkg::ST_LIMIT;
                    state_next   = S_RESP;
                end
                else
                begin
                    off_next   = top_reg;
                    size_next  = grow[OW-1:0];
                    top_next   = top_grow[OW-1:0];
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                // split off the remainder as a new free block
                if (rem >= OW'(ffa_pkg::SPLIT_MIN))
                begin
                    we          = 1'b1;
                    waddr       = IW'((off_reg + need_reg) >> ffa_pkg::GRAIN_SH);
                    wdata.valid = 1'b1;
                    wdata.size  = rem;
                    size_next   = need_reg;
                end
                used_next  = 1'b1;
                state_next = S_WRI;
            end
            S_FCHK:
            begin
                if (!rd.valid)
                begin
                    pend_st_next = ffa_pkg::ST_INVAL;
                    state_next   = S_RESP;
                end
                else if (!rd.used)
                begin
                    pend_st_next = ffa_pkg::ST_DOUBLE;
                    state_next   = S_RESP;
                end
                else
                begin
                    size_next  = rd.size;
                    used_next  = 1'b0;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                raddr = next_off[ffa_pkg::GRAIN_SH +: IW];
                if (size_reg == '0 || next_off >= {1'b0, top_reg})
                begin
                    state_next = S_WRI;
                end
                else
                begin
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (!rd.valid || rd.used || rd.size == '0)
                begin
                    state_next = S_WRI;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = next_off[ffa_pkg::GRAIN_SH +: IW];
                    size_next  = size_reg + rd.size;
                    state_next = S_MRD;
                end
            end
            S_WRI:
            begin
                we          = 1'b1;
                wdata.valid = 1'b1;
                wdata.used  = used_reg;
                wdata.size  = size_reg;
                pend_st_next = ffa_pkg::ST_OK;
                if (alloc_reg)
                begin
                    pend_addr_next = base_reg + 32'(off_reg) + 32'(ffa_pkg::HEADER_BYTES);
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            base_reg      <= '0;
            limit_reg     <= 5'd16;
            top_reg       <= OW'(ffa_pkg::INIT_BYTES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            if (cfg.valid)
            begin
                if (cfg.index == ffa_pkg::REG_BASE)
                begin
                    base_reg <= cfg.wdata;
                end
                else
                begin
                    limit_reg <= cfg.wdata[4:0];
                end
            end
            if (state_reg == S_RESP && rsp_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg       <= off_next;
        need_reg      <= need_next;
        size_reg      <= size_next;
        used_reg      <= used_next;
        alloc_reg     <= alloc_next;
        pend_addr_reg <= pend_addr_next;
        pend_st_reg   <= pend_st_next;
        if (state_reg == S_RESP && rsp_free)
        begin
            out_addr_reg <= pend_addr_reg;
            out_st_reg   <= pend_st_reg;
        end
    end

endmodule

FILE: tb/sv/first_fit_heap_allocator_top_test.sv
module first_fit_heap_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    ffa_req_if req ();
    ffa_rsp_if rsp ();
    ffa_cfg_if cfg ();

    first_fit_heap_allocator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    typedef struct packed {
        logic [31:0] payload_addr;
        logic [1:0]  status;
    } answer_t;

    // Mirror of the header table, one slot per grain offset.
    bit          mir_valid [0:ffa_pkg::SLOTS];
    bit          mir_used  [0:ffa_pkg::SLOTS];
    int unsigned mir_size  [0:ffa_pkg::SLOTS];
    int unsigned mir_top;
    logic [31:0] mir_base;
    int unsigned mir_limit_pages;

    answer_t     pending_answers[$];
    logic [31:0] live_addrs[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    function automatic int unsigned limit_bytes();
        int unsigned lim;
        lim = mir_limit_pages * ffa_pkg::PAGE_BYTES;
        if (lim > ffa_pkg::HEAP_BYTES)
            lim = ffa_pkg::HEAP_BYTES;
        return lim;
    endfunction

    function automatic logic [31:0] claim_block(int unsigned off, int unsigned need);
        int unsigned i;
        int unsigned j;
        i = off / ffa_pkg::GRAIN_BYTES;
        if (mir_size[i] - need >= ffa_pkg::SPLIT_MIN)
        begin
            j = (off + need) / ffa_pkg::GRAIN_BYTES;
            mir_valid[j] = 1'b1;
            mir_used[j]  = 1'b0;
            mir_size[j]  = mir_size[i] - need;
            mir_size[i]  = need;
        end
        mir_used[i] = 1'b1;
        return mir_base + off + ffa_pkg::HEADER_BYTES;
    endfunction

    function automatic answer_t heap_answer(logic op, logic [15:0] sz, logic [31:0] addr);
        answer_t     a;
        int unsigned need;
        int unsigned off;
        int unsigned grow;
        int unsigned i;
        int unsigned j;
        logic [31:0] o32;
        a.payload_addr = '0;
        a.status = ffa_pkg::ST_OK;
        if (op == ffa_pkg::OP_ALLOC)
        begin
            if (sz == 0)
            begin
                a.status = ffa_pkg::ST_INVAL;
                return a;
            end
            need = ((sz + ffa_pkg::HEADER_BYTES + ffa_pkg::GRAIN_BYTES - 1)
                    / ffa_pkg::GRAIN_BYTES) * ffa_pkg::GRAIN_BYTES;
            off = 0;
            while (off < mir_top)
            begin
                i = off / ffa_pkg::GRAIN_BYTES;
                if (!mir_valid[i] || mir_size[i] == 0)
                    break;
                if (!mir_used[i] && need <= mir_size[i])
                begin
                    a.payload_addr = claim_block(off, need);
                    return a;
                end
                off += mir_size[i];
            end
            grow = ((need + ffa_pkg::PAGE_BYTES - 1) / ffa_pkg::PAGE_BYTES)
                   * ffa_pkg::PAGE_BYTES;
            if (grow > limit_bytes() || mir_top > limit_bytes() - grow)
            begin
                a.status = ffa_pkg::ST_LIMIT;
                return a;
            end
            i = mir_top / ffa_pkg::GRAIN_BYTES;
            mir_valid[i] = 1'b1;
            mir_used[i]  = 1'b0;
            mir_size[i]  = grow;
            off = mir_top;
            mir_top += grow;
            a.payload_addr = claim_block(off, need);
            return a;
        end
        o32 = addr - mir_base - ffa_pkg::HEADER_BYTES;
        if (o32 % ffa_pkg::GRAIN_BYTES != 0 || o32 >= mir_top
            || !mir_valid[o32 / ffa_pkg::GRAIN_BYTES])
        begin
            a.status = ffa_pkg::ST_INVAL;
            return a;
        end
        off = o32;
        i = off / ffa_pkg::GRAIN_BYTES;
        if (!mir_used[i])
        begin
            a.status = ffa_pkg::ST_DOUBLE;
            return a;
        end
        mir_used[i] = 1'b0;
        // forward merge, stops at the top
        forever
        begin
            if (mir_size[i] == 0 || off + mir_size[i] >= mir_top)
                break;
            j = (off + mir_size[i]) / ffa_pkg::GRAIN_BYTES;
            if (!mir_valid[j] || mir_used[j] || mir_size[j] == 0)
                break;
            mir_size[i] += mir_size[j];
            mir_valid[j] = 1'b0;
            mir_size[j]  = 0;
        end
        return a;
    endfunction

    task automatic heap_reset_mirror();
        for (int k = 0; k <= ffa_pkg::SLOTS; k++)
        begin
            mir_valid[k] = 1'b0;
            mir_used[k]  = 1'b0;
            mir_size[k]  = 0;
        end
        mir_valid[0] = 1'b1;
        mir_size[0]  = ffa_pkg::INIT_BYTES;
        mir_top = ffa_pkg::INIT_BYTES;
        mir_base = '0;
        mir_limit_pages = 16;
    endtask

    // Send one request word; prediction happens at acceptance.
    task automatic send_request(logic op, logic [15:0] sz, logic [31:0] addr);
        answer_t a;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        req.valid      = 1'b1;
        req.operation  = op;
        req.req_size   = sz;
        req.block_addr = addr;
        forever
        begin
            @(posedge clk);
            if (req.ready)
                break;
        end
        a = heap_answer(op, sz, addr);
        pending_answers.push_back(a);
        if (op == ffa_pkg::OP_ALLOC && a.status == ffa_pkg::ST_OK)
            live_addrs.push_back(a.payload_addr);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.wdata = value;
        forever
        begin
            @(posedge clk);
            if (cfg.ready)
                break;
        end
        if (idx == ffa_pkg::REG_BASE)
            mir_base = value;
        else
            mir_limit_pages = value[4:0];
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic alloc_random();
        logic [15:0] sz;
        case ($urandom_range(0, 9))
            0:       sz = 16'($urandom_range(4096, 65535));
            1:       sz = 16'($urandom_range(0, 3));
            default: sz = 16'($urandom_range(1, 600));
        endcase
        send_request(ffa_pkg::OP_ALLOC, sz, 32'($urandom));
    endtask

    task automatic free_random();
        logic [31:0] addr;
        int          k;
        int          pick;
        pick = $urandom_range(0, 9);
        if (live_addrs.size() != 0 && pick < 7)
        begin
            k = $urandom_range(0, live_addrs.size() - 1);
            addr = live_addrs[k];
            live_addrs.delete(k);
        end
        else if (pick < 9)
            addr = mir_base + ffa_pkg::HEADER_BYTES + 4 * $urandom_range(0, 300);
        else
            addr = $urandom;
        send_request(ffa_pkg::OP_FREE, 16'($urandom), addr);
    endtask

    // Edge sizes, zero size, limit, bad address and double free.
    task automatic test_directed();
        logic [31:0] a0;
        logic [31:0] a1;
        send_request(ffa_pkg::OP_ALLOC, 16'd0, 32'hFFFF_FFFF);
        send_request(ffa_pkg::OP_ALLOC, 16'd1, 32'd0);
        a0 = mir_base + ffa_pkg::HEADER_BYTES;
        send_request(ffa_pkg::OP_ALLOC, 16'd100, 32'd0);
        a1 = live_addrs[$];
        send_request(ffa_pkg::OP_FREE, 16'hFFFF, a0);
        send_request(ffa_pkg::OP_FREE, 16'd0, a0);              // double free
        send_request(ffa_pkg::OP_FREE, 16'd0, a0 + 2);          // unaligned
        send_request(ffa_pkg::OP_FREE, 16'd0, 32'hFFFF_FFFF);   // beyond top
        send_request(ffa_pkg::OP_FREE, 16'd0, a1 + 4);          // not a block start
        send_request(ffa_pkg::OP_ALLOC, 16'd4088, 32'd0);       // exactly one page
        send_request(ffa_pkg::OP_ALLOC, 16'd65535, 32'd0);      // over the limit
        send_request(ffa_pkg::OP_ALLOC, 16'd20000, 32'd0);
        send_request(ffa_pkg::OP_FREE, 16'd0, a1);
        send_request(ffa_pkg::OP_ALLOC, 16'd3, 32'd0);
        live_addrs.delete();
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(ffa_pkg::REG_BASE, 32'hFFFF_FFF0);         // payload address wraps
        write_reg(ffa_pkg::REG_LIMIT, 32'hFFFF_FFE1);        // limit 1 page
        repeat (12) alloc_random();
        repeat (6) free_random();
        drain();
        write_reg(ffa_pkg::REG_LIMIT, 32'd0);                // every growth fails
        repeat (10) alloc_random();
        drain();
        write_reg(ffa_pkg::REG_LIMIT, 32'd31);
        write_reg(ffa_pkg::REG_BASE, 32'h0000_0000);
        live_addrs.delete();
    endtask

    // Receiver holds off long while requests keep coming.
    task automatic test_backpressure();
        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (20) alloc_random();
        join
        drain();
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            write_reg(ffa_pkg::REG_BASE, (phase == 3) ? 32'hFFFF_FFFF : 32'($urandom));
            write_reg(ffa_pkg::REG_LIMIT, 32'($urandom_range(1, 16)));
            live_addrs.delete();
            repeat (140)
            begin
                if ($urandom_range(0, 1) == 0)
                    alloc_random();
                else
                    free_random();
            end
        end
        drain();
    endtask

    // Result checker with random stalls.
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected word addr=%h status=%0d", $time,
                         rsp.payload_addr, rsp.status);
                errors++;
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (rsp.payload_addr !== exp_a.payload_addr)
                begin
                    $display("%0t: payload_addr expected %h actual %h", $time,
                             exp_a.payload_addr, rsp.payload_addr);
                    errors++;
                end
                if (rsp.status !== exp_a.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_a.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int wait_n;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else if (rsp.valid && rsp.ready)
            begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (wait_n != 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (wait_n) @(negedge clk);
                end
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no acceptance; covers the clearing pass too.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        req.valid      = 1'b0;
        req.operation  = ffa_pkg::OP_ALLOC;
        req.req_size   = '0;
        req.block_addr = '0;
        cfg.valid      = 1'b0;
        cfg.index      = ffa_pkg::REG_BASE;
        cfg.wdata      = '0;
        heap_reset_mirror();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_mix();
        if (errors == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/ffa_pkg.sv
sv/ffa_req_if.sv
sv/ffa_rsp_if.sv
sv/ffa_cfg_if.sv
sv/ffa_ram.sv
sv/first_fit_heap_allocator_top.sv
tb/sv/first_fit_heap_allocator_top_test.sv
